/* rtl/ssp_pkg.sv */
// Shared types, codes and constants of the state-space predictor.
package ssp_pkg;

    localparam int DEF_ORDER_LIMIT = 8;
    localparam int DEF_MAX_INPUTS  = 4;
    localparam int DEF_MAX_OUTPUTS = 4;

    localparam int STORE_DEPTH = 384;
    localparam int ADDR_W      = 9;
    localparam int COEF_W      = 18;
    localparam int SIG_W       = 16;
    localparam int ERR_W       = 17;
    localparam int STATE_W     = 24;
    localparam int PROD_W      = 42;
    localparam int ACC_W       = 48;
    localparam int CNT_W       = 4;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 4;

    // item opcodes
    localparam logic [1:0] OP_WRITE   = 2'd0;
    localparam logic [1:0] OP_SAMPLE  = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    // coefficient blocks
    localparam logic [2:0] SEL_A  = 3'd0;
    localparam logic [2:0] SEL_B  = 3'd1;
    localparam logic [2:0] SEL_C  = 3'd2;
    localparam logic [2:0] SEL_D  = 3'd3;
    localparam logic [2:0] SEL_K  = 3'd4;
    localparam logic [2:0] SEL_X0 = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODEL_ORDER  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INPUT_COUNT  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_COUNT = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PREDICT_MODE = 4'd3;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_Y,
        ST_DRAIN_Y,
        ST_X,
        ST_DRAIN_X,
        ST_EMIT,
        ST_X0,
        ST_DRAIN_X0
    } ctrl_state_t;

    typedef enum logic [1:0] {
        KIND_Y,
        KIND_X,
        KIND_X0
    } kind_t;

    typedef enum logic [2:0] {
        OPS_X,
        OPS_U,
        OPS_U4,
        OPS_E,
        OPS_ONE,
        OPS_ZERO
    } opsel_t;

    typedef enum logic [2:0] {
        SEG_M,
        SEG_U,
        SEG_K,
        SEG_Z,
        SEG_NONE
    } seg_t;

    typedef struct packed {
        logic              valid;
        logic              first;
        logic              last;
        kind_t             kind;
        opsel_t            opsel;
        logic [CNT_W-1:0]  row;
        logic [CNT_W-1:0]  j;
    } mac_cmd_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [COEF_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } ram_cmd_t;

    typedef struct packed {
        logic              load_inputs;
        logic              commit;
        logic              emit;
        logic [CNT_W-1:0]  order;
    } dp_ctrl_t;

    typedef struct packed {
        logic busy;
        logic out_full;
    } dp_stat_t;

endpackage

/* rtl/ssp_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module ssp_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/ssp_ctrl.sv */
// Controller: configuration registers, clearing sweep and term sequencer.
module ssp_ctrl import ssp_pkg::*; #(
    parameter int ORDER_LIMIT = DEF_ORDER_LIMIT,
    parameter int MAX_INPUTS  = DEF_MAX_INPUTS,
    parameter int MAX_OUTPUTS = DEF_MAX_OUTPUTS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            op,
    input  logic [2:0]            coef_sel,
    input  logic [5:0]            coef_addr,
    input  logic signed [17:0]    coef_value,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output ram_cmd_t              ram_cmd,
    output mac_cmd_t              mac_cmd,
    output dp_ctrl_t              dp_ctrl,
    input  dp_stat_t              dp_stat
);

    localparam int ORDER_CAP = (ORDER_LIMIT < 8) ? ORDER_LIMIT : 8;

    ctrl_state_t       state_reg, state_next;
    logic [3:0]        order_reg;
    logic [2:0]        inputs_reg, outputs_reg;
    logic              mode_reg;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic [CNT_W-1:0]  i_reg, i_next, j_reg, j_next;
    seg_t              seg_reg, seg_next;

    logic [CNT_W-1:0]  n_cnt, r_cnt, m_cnt, rows, seg_len;
    logic              accept, k_on, j_last, row_last, is_x;
    seg_t              nseg, first_y;
    logic [2:0]        msel;

    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // clamp the counts
    always_comb
    begin
        n_cnt = (order_reg > CNT_W'(ORDER_CAP)) ? CNT_W'(ORDER_CAP) : order_reg;
        r_cnt = (inputs_reg > 3'(MAX_INPUTS)) ? CNT_W'(MAX_INPUTS) : CNT_W'(inputs_reg);
        m_cnt = (outputs_reg > 3'(MAX_OUTPUTS)) ? CNT_W'(MAX_OUTPUTS) : CNT_W'(outputs_reg);
        k_on  = mode_reg && (m_cnt != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg   <= 4'd1;
            inputs_reg  <= 3'd1;
            outputs_reg <= 3'd1;
            mode_reg    <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_MODEL_ORDER:  order_reg   <= cfg_data;
                REG_INPUT_COUNT:  inputs_reg  <= cfg_data[2:0];
                REG_OUTPUT_COUNT: outputs_reg <= cfg_data[2:0];
                REG_PREDICT_MODE: mode_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // term sequence of one row
    always_comb
    begin
        is_x    = (state_reg == ST_X);
        first_y = (n_cnt != '0) ? SEG_M : ((r_cnt != '0) ? SEG_U : SEG_Z);
        case (seg_reg)
            SEG_M:   seg_len = n_cnt;
            SEG_U:   seg_len = r_cnt;
            SEG_K:   seg_len = m_cnt;
            default: seg_len = CNT_W'(1);
        endcase
        case (seg_reg)
            SEG_M:   nseg = (r_cnt != '0) ? SEG_U : ((is_x && k_on) ? SEG_K : SEG_NONE);
            SEG_U:   nseg = (is_x && k_on) ? SEG_K : SEG_NONE;
            default: nseg = SEG_NONE;
        endcase
        rows     = (state_reg == ST_Y) ? m_cnt : n_cnt;
        j_last   = (j_reg + CNT_W'(1)) == seg_len;
        row_last = (i_reg + CNT_W'(1)) == rows;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
                if (clr_reg == ADDR_W'(STORE_DEPTH - 1))
                    state_next = ST_IDLE;
            ST_IDLE:
                if (accept && op == OP_SAMPLE)
                    state_next = (m_cnt != '0) ? ST_Y : ST_DRAIN_Y;
                else if (accept && op == OP_RESTART && n_cnt != '0)
                    state_next = ST_X0;
            ST_Y:
                if (j_last && nseg == SEG_NONE && row_last)
                    state_next = ST_DRAIN_Y;
            ST_DRAIN_Y:
                if (!dp_stat.busy)
                    state_next = (n_cnt != '0) ? ST_X : ST_EMIT;
            ST_X:
                if (j_last && nseg == SEG_NONE && row_last)
                    state_next = ST_DRAIN_X;
            ST_DRAIN_X:
                if (!dp_stat.busy)
                    state_next = ST_EMIT;
            ST_EMIT:
                if (!dp_stat.out_full)
                    state_next = ST_IDLE;
            ST_X0:
                if (row_last)
                    state_next = ST_DRAIN_X0;
            ST_DRAIN_X0:
                if (!dp_stat.busy)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // counters
    always_comb
    begin
        clr_next = clr_reg;
        i_next   = i_reg;
        j_next   = j_reg;
        seg_next = seg_reg;
        case (state_reg)
            ST_CLEAR:
                clr_next = clr_reg + ADDR_W'(1);
            ST_IDLE:
            begin
                i_next   = '0;
                j_next   = '0;
                seg_next = (op == OP_SAMPLE) ? first_y : SEG_Z;
            end
            ST_Y, ST_X:
                if (!j_last)
                    j_next = j_reg + CNT_W'(1);
                else if (nseg != SEG_NONE)
                begin
                    j_next   = '0;
                    seg_next = nseg;
                end
                else
                begin
                    j_next   = '0;
                    i_next   = i_reg + CNT_W'(1);
                    seg_next = is_x ? SEG_M : first_y;
                end
            ST_DRAIN_Y:
            begin
                i_next   = '0;
                j_next   = '0;
                seg_next = SEG_M;
            end
            ST_X0:
                i_next = i_reg + CNT_W'(1);
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            seg_reg   <= SEG_NONE;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            seg_reg   <= seg_next;
        end
    end

    // outputs
    always_comb
    begin
        in_ready = (state_reg == ST_IDLE);

        ram_cmd.we    = 1'b0;
        ram_cmd.waddr = clr_reg;
        ram_cmd.wdata = '0;
        if (state_reg == ST_CLEAR)
            ram_cmd.we = 1'b1;
        else if (accept && op == OP_WRITE && coef_sel <= SEL_X0)
        begin
            ram_cmd.we    = 1'b1;
            ram_cmd.waddr = {coef_sel, coef_addr};
            ram_cmd.wdata = coef_value;
        end

        mac_cmd.valid = (state_reg inside {ST_Y, ST_X, ST_X0});
        mac_cmd.first = (j_reg == '0) && (seg_reg == (is_x ? SEG_M : first_y)
                        || state_reg == ST_X0);
        mac_cmd.last  = (state_reg == ST_X0) || (j_last && nseg == SEG_NONE);
        mac_cmd.row   = i_reg;
        mac_cmd.j     = j_reg;
        mac_cmd.kind  = KIND_Y;
        mac_cmd.opsel = OPS_ZERO;
        msel          = SEL_C;
        case (state_reg)
            ST_Y:
                case (seg_reg)
                    SEG_M:   begin msel = SEL_C; mac_cmd.opsel = OPS_X;  end
                    SEG_U:   begin msel = SEL_D; mac_cmd.opsel = OPS_U4; end
                    default: begin msel = SEL_C; mac_cmd.opsel = OPS_ZERO; end
                endcase
            ST_X:
            begin
                mac_cmd.kind = KIND_X;
                case (seg_reg)
                    SEG_M:   begin msel = SEL_A; mac_cmd.opsel = OPS_X; end
                    SEG_U:   begin msel = SEL_B; mac_cmd.opsel = OPS_U; end
                    default: begin msel = SEL_K; mac_cmd.opsel = OPS_E; end
                endcase
            end
            ST_X0:
            begin
                mac_cmd.kind  = KIND_X0;
                mac_cmd.opsel = OPS_ONE;
                msel          = SEL_X0;
            end
            default: ;
        endcase
        ram_cmd.raddr = (state_reg == ST_X0) ? {msel, i_reg[2:0], 3'd0}
                                             : {msel, i_reg[2:0], j_reg[2:0]};

        dp_ctrl.load_inputs = accept && op == OP_SAMPLE;
        dp_ctrl.commit      = (state_reg == ST_DRAIN_X) && !dp_stat.busy;
        dp_ctrl.emit        = (state_reg == ST_EMIT) && !dp_stat.out_full;
        dp_ctrl.order       = n_cnt;
    end

endmodule

/* rtl/ssp_dp.sv */
// Datapath: shared multiply-accumulate pipeline, state, innovation and result register.
module ssp_dp import ssp_pkg::*; #(
    parameter int ORDER_LIMIT = DEF_ORDER_LIMIT
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic signed [SIG_W-1:0]  u0, u1, u2, u3,
    input  logic signed [SIG_W-1:0]  ym0, ym1, ym2, ym3,
    input  logic signed [COEF_W-1:0] coef_rdata,
    input  mac_cmd_t                 mac_cmd,
    input  dp_ctrl_t                 dp_ctrl,
    output dp_stat_t                 dp_stat,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [SIG_W-1:0]  pred0, pred1, pred2, pred3,
    output logic                     saturated
);

    localparam int IW = (ORDER_LIMIT > 1) ? $clog2(ORDER_LIMIT) : 1;

    logic signed [SIG_W-1:0]   u_reg [4];
    logic signed [SIG_W-1:0]   ym_reg [4];
    logic signed [SIG_W-1:0]   y_reg [4];
    logic signed [ERR_W-1:0]   e_reg [4];
    logic signed [STATE_W-1:0] x_reg [ORDER_LIMIT];
    logic signed [STATE_W-1:0] xn_reg [ORDER_LIMIT];
    logic                      sat_reg;

    mac_cmd_t                  s1_reg, s2_reg, s3_reg;
    logic signed [STATE_W-1:0] opd_reg, opd_next;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;

    logic signed [ACC_W-1:0]   rnd_full, x0_full;
    logic signed [SIG_W-1:0]   y_clip;
    logic signed [STATE_W-1:0] x_clip;
    logic                      y_ovf, x_ovf;
    logic                      out_valid_reg;

    // operand of the current term
    always_comb
    begin
        case (mac_cmd.opsel)
            OPS_X:   opd_next = x_reg[mac_cmd.j[IW-1:0]];
            OPS_U:   opd_next = STATE_W'(u_reg[mac_cmd.j[1:0]]);
            OPS_U4:  opd_next = STATE_W'(u_reg[mac_cmd.j[1:0]]) <<< 2;
            OPS_E:   opd_next = STATE_W'(e_reg[mac_cmd.j[1:0]]);
            OPS_ONE: opd_next = STATE_W'(1);
            default: opd_next = '0;
        endcase
        acc_next = (s2_reg.first ? ACC_W'(0) : acc_reg) + ACC_W'(prod_reg);
    end

    // round half up, then clip
    always_comb
    begin
        rnd_full = (acc_reg + ACC_W'(8192)) >>> 14;
        x0_full  = (acc_reg + ACC_W'(2)) >>> 2;
        y_ovf    = (rnd_full > ACC_W'(32767)) || (rnd_full < -ACC_W'(32768));
        x_ovf    = (rnd_full > ACC_W'(8388607)) || (rnd_full < -ACC_W'(8388608));
        if (rnd_full > ACC_W'(32767))
            y_clip = 16'sh7fff;
        else if (rnd_full < -ACC_W'(32768))
            y_clip = 16'sh8000;
        else
            y_clip = rnd_full[SIG_W-1:0];
        if (rnd_full > ACC_W'(8388607))
            x_clip = 24'sh7fffff;
        else if (rnd_full < -ACC_W'(8388608))
            x_clip = 24'sh800000;
        else
            x_clip = rnd_full[STATE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
            s2_reg <= '0;
            s3_reg <= '0;
        end
        else
        begin
            s1_reg <= mac_cmd;
            s2_reg <= s1_reg;
            s3_reg <= s2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        opd_reg  <= opd_next;
        prod_reg <= PROD_W'(coef_rdata) * PROD_W'(opd_reg);
        if (s2_reg.valid)
            acc_reg <= acc_next;
    end

    // sample inputs, predictions, innovation and new state
    always_ff @(posedge clk)
    begin
        if (dp_ctrl.load_inputs)
        begin
            u_reg[0]  <= u0;  u_reg[1]  <= u1;  u_reg[2]  <= u2;  u_reg[3]  <= u3;
            ym_reg[0] <= ym0; ym_reg[1] <= ym1; ym_reg[2] <= ym2; ym_reg[3] <= ym3;
            for (int k = 0; k < 4; k++)
            begin
                y_reg[k] <= '0;
                e_reg[k] <= '0;
            end
        end
        else if (s3_reg.valid && s3_reg.last && s3_reg.kind == KIND_Y)
        begin
            y_reg[s3_reg.row[1:0]] <= y_clip;
            e_reg[s3_reg.row[1:0]] <= ERR_W'(ym_reg[s3_reg.row[1:0]]) - ERR_W'(y_clip);
        end
        if (s3_reg.valid && s3_reg.last && s3_reg.kind == KIND_X)
            xn_reg[s3_reg.row[IW-1:0]] <= x_clip;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < ORDER_LIMIT; k++)
                x_reg[k] <= '0;
            sat_reg <= 1'b0;
        end
        else
        begin
            if (dp_ctrl.commit)
            begin
                for (int k = 0; k < ORDER_LIMIT; k++)
                    if (CNT_W'(k) < dp_ctrl.order)
                        x_reg[k] <= xn_reg[k];
            end
            else if (s3_reg.valid && s3_reg.last && s3_reg.kind == KIND_X0)
                x_reg[s3_reg.row[IW-1:0]] <= x0_full[STATE_W-1:0];

            if (dp_ctrl.load_inputs)
                sat_reg <= 1'b0;
            else if (s3_reg.valid && s3_reg.last && s3_reg.kind == KIND_Y && y_ovf)
                sat_reg <= 1'b1;
            else if (s3_reg.valid && s3_reg.last && s3_reg.kind == KIND_X && x_ovf)
                sat_reg <= 1'b1;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (dp_ctrl.emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (dp_ctrl.emit)
        begin
            pred0     <= y_reg[0];
            pred1     <= y_reg[1];
            pred2     <= y_reg[2];
            pred3     <= y_reg[3];
            saturated <= sat_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign dp_stat.busy     = s1_reg.valid || s2_reg.valid || s3_reg.valid;
    assign dp_stat.out_full = out_valid_reg;

endmodule

/* rtl/state_space_predictor_top.sv */
// Top level of the state-space predictor: controller, datapath and coefficient RAM.
//
// Innovation-form state-space predictor. Coefficient items (op write) land in a 384-entry
// coefficient RAM and do not stall the input. A restart item reloads the state from the
// initial-state block, one state per cycle plus a short drain. A sample item first forms
// y = C x + 4 D u for each output in use, then x = A x + B u + K (ym - y), the K term only in
// predict mode, all through one shared 18 x 24 multiply-accumulate pipeline fed by the RAM's
// single read port, one term per cycle, with a drain after each pass and then the result
// load. The result item waits in an output register; the next item is taken once the
// current one has finished. After reset the RAM is swept to zero, which holds the input;
// configuration writes are taken at any time and never stall.
module state_space_predictor_top import ssp_pkg::*; #(
    parameter int ORDER_LIMIT = DEF_ORDER_LIMIT,
    parameter int MAX_INPUTS  = DEF_MAX_INPUTS,
    parameter int MAX_OUTPUTS = DEF_MAX_OUTPUTS
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [1:0]               op,
    input  logic [2:0]               coef_sel,
    input  logic [5:0]               coef_addr,
    input  logic signed [COEF_W-1:0] coef_value,
    input  logic signed [SIG_W-1:0]  u0,
    input  logic signed [SIG_W-1:0]  u1,
    input  logic signed [SIG_W-1:0]  u2,
    input  logic signed [SIG_W-1:0]  u3,
    input  logic signed [SIG_W-1:0]  ym0,
    input  logic signed [SIG_W-1:0]  ym1,
    input  logic signed [SIG_W-1:0]  ym2,
    input  logic signed [SIG_W-1:0]  ym3,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [SIG_W-1:0]  pred0,
    output logic signed [SIG_W-1:0]  pred1,
    output logic signed [SIG_W-1:0]  pred2,
    output logic signed [SIG_W-1:0]  pred3,
    output logic                     saturated,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data
);

    ram_cmd_t          ram_cmd;
    mac_cmd_t          mac_cmd;
    dp_ctrl_t          dp_ctrl;
    dp_stat_t          dp_stat;
    logic [COEF_W-1:0] coef_rdata;

    // sequence the terms and hold the configuration
    ssp_ctrl #(
        .ORDER_LIMIT (ORDER_LIMIT),
        .MAX_INPUTS  (MAX_INPUTS),
        .MAX_OUTPUTS (MAX_OUTPUTS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .coef_sel   (coef_sel),
        .coef_addr  (coef_addr),
        .coef_value (coef_value),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .ram_cmd    (ram_cmd),
        .mac_cmd    (mac_cmd),
        .dp_ctrl    (dp_ctrl),
        .dp_stat    (dp_stat)
    );

    // coefficient store: block of 64 per matrix, row*8+column inside
    ssp_ram #(
        .WIDTH (COEF_W),
        .DEPTH (STORE_DEPTH)
    ) u_coef_ram (
        .clk   (clk),
        .we    (ram_cmd.we),
        .waddr (ram_cmd.waddr),
        .wdata (ram_cmd.wdata),
        .raddr (ram_cmd.raddr),
        .rdata (coef_rdata)
    );

    // multiply-accumulate, state and result
    ssp_dp #(
        .ORDER_LIMIT (ORDER_LIMIT)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .u0         (u0),
        .u1         (u1),
        .u2         (u2),
        .u3         (u3),
        .ym0        (ym0),
        .ym1        (ym1),
        .ym2        (ym2),
        .ym3        (ym3),
        .coef_rdata (coef_rdata),
        .mac_cmd    (mac_cmd),
        .dp_ctrl    (dp_ctrl),
        .dp_stat    (dp_stat),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pred0      (pred0),
        .pred1      (pred1),
        .pred2      (pred2),
        .pred3      (pred3),
        .saturated  (saturated)
    );

endmodule

/* rtl/ssp_checker.sv */
// Port-level checker of the state-space predictor and its bind.
module ssp_checker import ssp_pkg::*; (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [1:0]  op,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] pred0,
    input logic        saturated
);

    // a waiting result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pred0) && $stable(saturated))
        else $error("result changed while stalled");

    // a sample item keeps the block busy
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && op == OP_SAMPLE |=> !in_ready)
        else $error("input taken during a sample step");

    // a coefficient write never stalls the input
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && op == OP_WRITE |=> in_ready)
        else $error("coefficient write stalled the input");

    // a result only appears at the end of a busy step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared while idle");

endmodule

bind state_space_predictor_top ssp_checker u_ssp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pred0     (pred0),
    .saturated (saturated)
);

/* test/state_space_predictor_top_tb.sv */
// Self-checking testbench of the state-space predictor: directed table, then random phases.
module state_space_predictor_top_tb;
    import ssp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT  = 4000;  // covers the RAM sweep after reset and a full sample
    localparam int SETTLE      = 40;    // a restart still draining after the last result
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 124;

    typedef struct {
        logic [1:0]               op;
        logic [2:0]               sel;
        logic [5:0]               addr;
        logic signed [COEF_W-1:0] val;
        logic signed [SIG_W-1:0]  u [4];
        logic signed [SIG_W-1:0]  ym [4];
    } ssp_item_t;

    typedef struct {
        logic signed [SIG_W-1:0] pred [4];
        logic                    sat;
    } ssp_pred_t;

    typedef struct {
        ssp_item_t               it;
        bit                      typed;
        logic signed [SIG_W-1:0] p0;
        logic                    sat;
    } stim_row_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic [1:0]               op = '0;
    logic [2:0]               coef_sel = '0;
    logic [5:0]               coef_addr = '0;
    logic signed [COEF_W-1:0] coef_value = '0;
    logic signed [SIG_W-1:0]  u0 = '0, u1 = '0, u2 = '0, u3 = '0;
    logic signed [SIG_W-1:0]  ym0 = '0, ym1 = '0, ym2 = '0, ym3 = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic signed [SIG_W-1:0]  pred0, pred1, pred2, pred3;
    logic                     saturated;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [CFG_DATA_W-1:0]    cfg_data = '0;

    state_space_predictor_top u_top (.*);

    always #4 clk = ~clk;

    // Shadow copy of the block: coefficient store, state vector, registers.
    logic signed [COEF_W-1:0] coef_mem [STORE_DEPTH];
    longint                   x_state [8];
    logic [3:0]               sh_order;
    logic [2:0]               sh_inputs;
    logic [2:0]               sh_outputs;
    logic                     sh_mode;

    ssp_pred_t   pending_preds [$];
    stim_row_t   stim_table [$];
    int          fail_count = 0;
    int          quiet_cycles = 0;
    bit          steady = 1'b0;     // when set, neither side idles
    int          ready_hold = 0;

    function automatic longint round_q12(input longint acc);
        return (acc + 64'sd8192) >>> 14;
    endfunction

    function automatic longint clip_to(input longint v, input int w, inout bit flag);
        longint hi;
        longint lo;
        hi = (64'sd1 <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) begin flag = 1'b1; return hi; end
        if (v < lo) begin flag = 1'b1; return lo; end
        return v;
    endfunction

    function automatic longint cf(input logic [2:0] sel, input int row, input int col);
        return longint'(coef_mem[sel * 64 + row * 8 + col]);
    endfunction

    // Advance the shadow model by one item; returns 1 when a result is due.
    function automatic bit advance_model(input ssp_item_t it, output ssp_pred_t res);
        int     n;
        int     r;
        int     m;
        longint acc;
        longint y [4];
        longint e [4];
        longint xn [8];
        bit     flag;
        n = (sh_order > 8) ? 8 : sh_order;
        r = (sh_inputs > 4) ? 4 : sh_inputs;
        m = (sh_outputs > 4) ? 4 : sh_outputs;
        flag = 1'b0;
        res.sat = 1'b0;
        for (int k = 0; k < 4; k++) res.pred[k] = '0;
        case (it.op)
            OP_WRITE: begin
                if (it.sel <= SEL_X0) coef_mem[it.sel * 64 + it.addr] = it.val;
                return 1'b0;
            end
            OP_RESTART: begin
                for (int i = 0; i < n; i++) x_state[i] = (cf(SEL_X0, i, 0) + 2) >>> 2;
                return 1'b0;
            end
            OP_SAMPLE: begin
                for (int k = 0; k < 4; k++) begin y[k] = 0; e[k] = 0; end
                for (int i = 0; i < m; i++) begin
                    acc = 0;
                    for (int j = 0; j < n; j++) acc += cf(SEL_C, i, j) * x_state[j];
                    for (int j = 0; j < r; j++) acc += cf(SEL_D, i, j) * longint'(it.u[j]) * 4;
                    y[i] = clip_to(round_q12(acc), 16, flag);
                    e[i] = longint'(it.ym[i]) - y[i];
                end
                for (int i = 0; i < n; i++) begin
                    acc = 0;
                    for (int j = 0; j < n; j++) acc += cf(SEL_A, i, j) * x_state[j];
                    for (int j = 0; j < r; j++) acc += cf(SEL_B, i, j) * longint'(it.u[j]);
                    if (sh_mode)
                        for (int j = 0; j < m; j++) acc += cf(SEL_K, i, j) * e[j];
                    xn[i] = clip_to(round_q12(acc), 24, flag);
                end
                for (int i = 0; i < n; i++) x_state[i] = xn[i];
                for (int k = 0; k < 4; k++) res.pred[k] = y[k][SIG_W-1:0];
                res.sat = flag;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic int gap_len();
        if (steady || $urandom_range(0, 2) != 0) return 0;
        if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    // Mostly modest coefficients so the state stays in range; now and then any value.
    function automatic logic signed [COEF_W-1:0] pick_coef();
        if ($urandom_range(0, 7) == 0) return COEF_W'($urandom);
        return COEF_W'(int'($urandom_range(0, 8191)) - 4096);
    endfunction

    function automatic ssp_item_t pick_item();
        ssp_item_t it;
        int        roll;
        roll = $urandom_range(0, 99);
        it.op   = (roll < 40) ? OP_WRITE : (roll < 91) ? OP_SAMPLE :
                  (roll < 97) ? OP_RESTART : 2'd3;
        it.sel  = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                               : 3'($urandom_range(0, 5));
        it.addr = 6'($urandom);
        it.val  = pick_coef();
        for (int k = 0; k < 4; k++) begin
            it.u[k]  = SIG_W'($urandom);
            it.ym[k] = SIG_W'($urandom);
        end
        return it;
    endfunction

    function automatic stim_row_t row(input logic [1:0] o, input logic [2:0] s,
                                      input logic [5:0] a, input int v,
                                      input int uu, input int yy,
                                      input bit typed, input int p, input bit sat);
        stim_row_t t;
        t.it.op = o; t.it.sel = s; t.it.addr = a; t.it.val = COEF_W'(v);
        for (int k = 0; k < 4; k++) begin
            t.it.u[k]  = SIG_W'(uu);
            t.it.ym[k] = SIG_W'(yy);
        end
        t.typed = typed; t.p0 = SIG_W'(p); t.sat = sat;
        return t;
    endfunction

    // Present one item after a random gap and hold it until taken.
    task automatic send_item(input ssp_item_t it, input bit typed, input ssp_pred_t typed_res);
        int        g;
        ssp_pred_t res;
        g = gap_len();
        if (g > 0) begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        op <= it.op; coef_sel <= it.sel; coef_addr <= it.addr; coef_value <= it.val;
        u0 <= it.u[0]; u1 <= it.u[1]; u2 <= it.u[2]; u3 <= it.u[3];
        ym0 <= it.ym[0]; ym1 <= it.ym[1]; ym2 <= it.ym[2]; ym3 <= it.ym[3];
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        if (advance_model(it, res)) pending_preds.push_back(typed ? typed_res : res);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_MODEL_ORDER:  sh_order   = val;
            REG_INPUT_COUNT:  sh_inputs  = val[2:0];
            REG_OUTPUT_COUNT: sh_outputs = val[2:0];
            REG_PREDICT_MODE: sh_mode    = val[0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Drop valid, then wait until every result is back and any trailing work is done.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_preds.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Receiver stalls: short mostly, a few long.
    always @(posedge clk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
            out_ready  <= 1'b0;
        end
        else begin
            out_ready <= 1'b1;
            if (!steady && $urandom_range(0, 3) == 0) ready_hold <= gap_len();
        end
    end

    // Compare each result with the oldest expectation.
    always @(posedge clk) begin
        ssp_pred_t want;
        logic signed [SIG_W-1:0] got [4];
        if (rst_n && out_valid && out_ready) begin
            got = '{pred0, pred1, pred2, pred3};
            if (pending_preds.size() == 0) begin
                $error("unexpected result item");
                fail_count++;
            end
            else begin
                want = pending_preds.pop_front();
                for (int k = 0; k < 4; k++)
                    if (got[k] !== want.pred[k]) begin
                        $error("pred%0d expected %0d got %0d", k, want.pred[k], got[k]);
                        fail_count++;
                    end
                if (saturated !== want.sat) begin
                    $error("saturated expected %0b got %0b", want.sat, saturated);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: count cycles in which no channel moves an item.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("FAIL state_space_predictor_top");
            $finish;
        end
    end

    initial begin
        ssp_pred_t none;
        ssp_pred_t fixed;
        stim_row_t t;
        int        cfg_pick [4];
        none.sat = 1'b0;
        for (int k = 0; k < 4; k++) none.pred[k] = '0;
        for (int k = 0; k < STORE_DEPTH; k++) coef_mem[k] = '0;
        for (int k = 0; k < 8; k++) x_state[k] = 0;
        sh_order = 4'd1; sh_inputs = 3'd1; sh_outputs = 3'd1; sh_mode = 1'b1;

        // Directed table under reset configuration (one state, input and output).
        stim_table.push_back(row(OP_SAMPLE,  SEL_A,  0,       0,  32767, -32768, 1, 0, 0));
        stim_table.push_back(row(2'd3,       SEL_D,  0,  131071,  32767,  32767, 0, 0, 0));
        stim_table.push_back(row(OP_WRITE,   3'd7,  63, -131072,      0,      0, 0, 0, 0));
        stim_table.push_back(row(OP_WRITE,   3'd6,   0,  131071,      0,      0, 0, 0, 0));
        stim_table.push_back(row(OP_SAMPLE,  SEL_A,  0,       0,     -1,     -1, 1, 0, 0));
        stim_table.push_back(row(OP_WRITE,   SEL_D,  0,  131071,      0,      0, 0, 0, 0));
        stim_table.push_back(row(OP_SAMPLE,  SEL_A,  0,       0,  32767,      0, 1, 32767, 1));
        stim_table.push_back(row(OP_SAMPLE,  SEL_A,  0,       0, -32768,      0, 1, -32768, 1));
        stim_table.push_back(row(OP_WRITE,   SEL_D,  0,       0,      0,      0, 0, 0, 0));
        stim_table.push_back(row(OP_WRITE,   SEL_X0, 0,  131071,      0,      0, 0, 0, 0));
        stim_table.push_back(row(OP_RESTART, SEL_A,  0,       0,      0,      0, 0, 0, 0));
        stim_table.push_back(row(OP_WRITE,   SEL_C,  0,   16384,      0,      0, 0, 0, 0));
        stim_table.push_back(row(OP_SAMPLE,  SEL_A,  0,       0,   1234,   -777, 0, 0, 0));
        stim_table.push_back(row(OP_WRITE,   SEL_A,  0, -131072,      0,      0, 0, 0, 0));
        stim_table.push_back(row(OP_WRITE,   SEL_K,  0,  131071,      0,      0, 0, 0, 0));
        stim_table.push_back(row(OP_WRITE,   SEL_B,  0, -131072,      0,      0, 0, 0, 0));
        stim_table.push_back(row(OP_SAMPLE,  SEL_A,  0,       0, -32768,  32767, 0, 0, 0));
        stim_table.push_back(row(OP_SAMPLE,  SEL_A,  0,       0,  32767, -32768, 0, 0, 0));
        stim_table.push_back(row(OP_WRITE,   SEL_X0, 0, -131072,      0,      0, 0, 0, 0));
        stim_table.push_back(row(OP_RESTART, SEL_A,  0,       0,      0,      0, 0, 0, 0));
        stim_table.push_back(row(OP_SAMPLE,  SEL_A,  0,       0,      5,     -5, 0, 0, 0));
        stim_table.push_back(row(OP_WRITE,   SEL_C, 63,       5,      0,      0, 0, 0, 0));
        stim_table.push_back(row(OP_SAMPLE,  SEL_A,  0,       0,    -42,     42, 0, 0, 0));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_table[i]) begin
            t = stim_table[i];
            fixed = none;
            fixed.pred[0] = t.p0;
            fixed.sat = t.sat;
            send_item(t.it, t.typed, fixed);
        end
        drain();

        // Random phases: fresh register setting, a burst of fresh coefficients, then mixed items.
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: cfg_pick = '{8, 4, 4, 1};
                1: cfg_pick = '{0, 0, 0, 0};
                2: cfg_pick = '{15, 7, 7, 1};
                3: cfg_pick = '{1, 1, 1, 0};
                default: cfg_pick = '{$urandom_range(0, 15), $urandom_range(0, 15),
                                      $urandom_range(0, 15), $urandom_range(0, 15)};
            endcase
            write_reg(REG_MODEL_ORDER,  CFG_DATA_W'(cfg_pick[0]));
            write_reg(REG_INPUT_COUNT,  CFG_DATA_W'(cfg_pick[1]));
            write_reg(REG_OUTPUT_COUNT, CFG_DATA_W'(cfg_pick[2]));
            write_reg(REG_PREDICT_MODE, CFG_DATA_W'(cfg_pick[3]));
            // an index beyond the register list must be ignored
            write_reg(CFG_IDX_W'($urandom_range(4, 15)), CFG_DATA_W'($urandom));
            steady = (ph % 4 == 3);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                t.it = pick_item();
                if (k < 24) t.it.op = OP_WRITE;
                else if (k == 24) t.it.op = OP_RESTART;
                send_item(t.it, 1'b0, none);
            end
            drain();
        end

        if (fail_count == 0)
            $display("PASS state_space_predictor_top");
        else
            $display("FAIL state_space_predictor_top");
        $finish;
    end

endmodule
